// ----- rtl/polynomial_bisection_root_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bisection root core
// Shared concurrent assertion forms, clocked on clk_i, idle during reset.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_BISECTION_ROOT_CORE_DEFINES_SVH
`define POLYNOMIAL_BISECTION_ROOT_CORE_DEFINES_SVH

// same-cycle implication
`define PBR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pbr assertion failed");

// next-cycle implication
`define PBR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbr assertion failed");

`endif

// ----- rtl/pbr_pkg.sv -----
// ----------------------------------------------------------------------------
// pbr_pkg
// Types and constants shared by the bisection root controller and datapath.
// ----------------------------------------------------------------------------
package pbr_pkg;

  // default parameter values
  localparam int unsigned DEF_MAX_DEGREE = 5;
  localparam int unsigned DEF_MAX_ITER   = 10000;
  localparam int unsigned DEF_FRAC_BITS  = 16;

  // fixed field widths
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned TOL_W      = 31;
  localparam int unsigned DEG_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned COEF_IDX_W = 3;

  // register indexes beyond the coefficients
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TOL    = 3'd7;

  // register reset values
  localparam logic [DEG_W-1:0] DEGREE_RST = 3'd2;
  localparam logic [TOL_W-1:0] TOL_RST    = 31'd1;

  // datapath commands
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SEL_LO,
    DP_SEL_HI,
    DP_SEL_MID,
    DP_MUL_TC,
    DP_MUL_TX,
    DP_UPD_T,
    DP_SAVE_VR,
    DP_MOVE,
    DP_RES_X,
    DP_RES_ZERO
  } dp_op_e;

  typedef struct packed {
    dp_op_e                op;
    logic [COEF_IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic             tol_hit;
    logic [DEG_W-1:0] deg_eff;
  } dp_status_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_MUL_TC,
    ST_MUL_TX,
    ST_UPD_T,
    ST_CHECK,
    ST_FINISH
  } ctrl_state_e;

  // evaluation point within one pass
  typedef enum logic [1:0] {
    PT_LO,
    PT_HI,
    PT_MID
  } point_e;

endpackage

// ----- rtl/pbr_datapath.sv -----
// ----------------------------------------------------------------------------
// pbr_datapath
// Config registers, bounds, shared 32x32 multiplier, saturating accumulate,
// tolerance compare and result register.
// ----------------------------------------------------------------------------
module pbr_datapath import pbr_pkg::*; #(
  parameter int unsigned MAX_DEGREE = DEF_MAX_DEGREE,
  parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  input  logic signed [DATA_W-1:0] lower_bound_i,
  input  logic signed [DATA_W-1:0] upper_bound_i,
  input  dp_cmd_t                  cmd_i,
  output dp_status_t               status_o,
  output logic signed [DATA_W-1:0] root_o,
  output logic                     converged_o
);

  localparam int unsigned NCOEF = MAX_DEGREE + 1;
  localparam int unsigned CW    = $clog2(NCOEF);
  localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [63:0] SAT_MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN64 = -64'sd2147483648;
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;

  // floor shift of a product, saturated to 32 bits
  function automatic logic signed [DATA_W-1:0] sat_prod(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> FRAC_BITS;
    if (s > SAT_MAX64) return S32_MAX;
    else if (s < SAT_MIN64) return S32_MIN;
    else return s[DATA_W-1:0];
  endfunction

  // saturating 32-bit add
  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? S32_MIN : S32_MAX;
    else return s[DATA_W-1:0];
  endfunction

  logic signed [DATA_W-1:0] coef_q [NCOEF];
  logic [DEG_W-1:0]         deg_q;
  logic [TOL_W-1:0]         tol_q;

  logic signed [DATA_W-1:0] lo_q, hi_q, x_q, t_q, y_q, vr_q, root_q;
  logic signed [63:0]       prod_q;
  logic                     conv_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCOEF; i++) coef_q[i] <= '0;
      deg_q <= DEGREE_RST;
      tol_q <= TOL_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_DEGREE) begin
        deg_q <= cfg_data_i[DEG_W-1:0];
      end else if (cfg_idx_i == REG_TOL) begin
        tol_q <= cfg_data_i[TOL_W-1:0];
      end else if (cfg_idx_i <= CFG_IDX_W'(MAX_DEGREE)) begin
        coef_q[cfg_idx_i[CW-1:0]] <= cfg_data_i;
      end
    end
  end

  // shared multiplier operands
  logic signed [DATA_W-1:0] mul_b;
  logic signed [63:0]       prod_full;
  assign mul_b     = (cmd_i.op == DP_MUL_TC) ? coef_q[cmd_i.idx[CW-1:0]] : x_q;
  assign prod_full = t_q * mul_b;

  // floor midpoint of the bounds
  logic [DATA_W:0]          sum_lh;
  logic signed [DATA_W-1:0] mid;
  assign sum_lh = {lo_q[DATA_W-1], lo_q} + {hi_q[DATA_W-1], hi_q};
  assign mid    = sum_lh[DATA_W:1];

  // sign test of midpoint value against right-bound value
  logic vm_neg, vm_pos, vr_neg, vr_pos, move_lo;
  assign vm_neg  = y_q[DATA_W-1];
  assign vm_pos  = !y_q[DATA_W-1] && (|y_q);
  assign vr_neg  = vr_q[DATA_W-1];
  assign vr_pos  = !vr_q[DATA_W-1] && (|vr_q);
  assign move_lo = (vm_neg && vr_pos) || (vm_pos && vr_neg);

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        lo_q <= lower_bound_i;
        hi_q <= upper_bound_i;
      end
      DP_SEL_LO, DP_SEL_HI, DP_SEL_MID: begin
        x_q <= (cmd_i.op == DP_SEL_LO) ? lo_q : (cmd_i.op == DP_SEL_HI) ? hi_q : mid;
        y_q <= '0;
        t_q <= ONE_FX;
      end
      DP_MUL_TC: prod_q <= prod_full;
      DP_MUL_TX: begin
        y_q    <= sat_add(y_q, sat_prod(prod_q));
        prod_q <= prod_full;
      end
      DP_UPD_T:   t_q  <= sat_prod(prod_q);
      DP_SAVE_VR: vr_q <= y_q;
      DP_MOVE: begin
        if (move_lo) lo_q <= x_q;
        else hi_q <= x_q;
      end
      DP_RES_X: begin
        root_q <= x_q;
        conv_q <= 1'b1;
      end
      DP_RES_ZERO: begin
        root_q <= '0;
        conv_q <= 1'b0;
      end
      default: ;
    endcase
  end

  // tolerance check on 33-bit magnitude
  logic [DATA_W:0] y_ext, y_mag;
  assign y_ext = {y_q[DATA_W-1], y_q};
  assign y_mag = y_q[DATA_W-1] ? ((DATA_W+1)'(0) - y_ext) : y_ext;

  assign status_o.tol_hit = y_mag < {2'b00, tol_q};
  assign status_o.deg_eff = (deg_q > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_q;

  assign root_o      = root_q;
  assign converged_o = conv_q;

endmodule

// ----- rtl/pbr_ctrl.sv -----
// ----------------------------------------------------------------------------
// pbr_ctrl
// Sequencer for bisection passes: term loop, point select, pass count,
// request handshakes and output valid.
// ----------------------------------------------------------------------------
module pbr_ctrl import pbr_pkg::*; #(
  parameter int unsigned MAX_ITER = DEF_MAX_ITER
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam int unsigned ITER_W = $clog2(MAX_ITER + 1);

  ctrl_state_e           state_q, state_d;
  point_e                pt_q, pt_d;
  logic [COEF_IDX_W-1:0] term_q, term_d;
  logic [ITER_W-1:0]     pass_q, pass_d;
  logic                  zero_q, zero_d;
  logic                  out_valid_q, out_valid_d;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d     = state_q;
    pt_d        = pt_q;
    term_d      = term_q;
    pass_d      = pass_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          pt_d    = PT_LO;
          pass_d  = '0;
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        if (pt_q == PT_LO && pass_q == ITER_W'(MAX_ITER)) begin
          zero_d  = 1'b1;
          state_d = ST_FINISH;
        end else begin
          term_d  = '0;
          state_d = ST_MUL_TC;
        end
      end
      ST_MUL_TC: state_d = ST_MUL_TX;
      ST_MUL_TX: state_d = (term_q == status_i.deg_eff) ? ST_CHECK : ST_UPD_T;
      ST_UPD_T: begin
        term_d  = term_q + 1'b1;
        state_d = ST_MUL_TC;
      end
      ST_CHECK: begin
        case (pt_q)
          PT_LO, PT_HI: begin
            if (status_i.tol_hit) begin
              zero_d  = 1'b0;
              state_d = ST_FINISH;
            end else begin
              pt_d    = (pt_q == PT_LO) ? PT_HI : PT_MID;
              state_d = ST_SEL;
            end
          end
          default: begin
            pass_d  = pass_q + 1'b1;
            pt_d    = PT_LO;
            state_d = ST_SEL;
          end
        endcase
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    cmd_o.op   = DP_NOP;
    cmd_o.idx  = term_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = DP_LOAD;
      end
      ST_SEL: begin
        if (!(pt_q == PT_LO && pass_q == ITER_W'(MAX_ITER))) begin
          case (pt_q)
            PT_LO:   cmd_o.op = DP_SEL_LO;
            PT_HI:   cmd_o.op = DP_SEL_HI;
            default: cmd_o.op = DP_SEL_MID;
          endcase
        end
      end
      ST_MUL_TC: cmd_o.op = DP_MUL_TC;
      ST_MUL_TX: cmd_o.op = DP_MUL_TX;
      ST_UPD_T:  cmd_o.op = DP_UPD_T;
      ST_CHECK: begin
        if (pt_q == PT_MID) cmd_o.op = DP_MOVE;
        else if (pt_q == PT_HI && !status_i.tol_hit) cmd_o.op = DP_SAVE_VR;
      end
      ST_FINISH: begin
        if (out_free) cmd_o.op = zero_q ? DP_RES_ZERO : DP_RES_X;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pt_q        <= PT_LO;
      term_q      <= '0;
      pass_q      <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pt_q        <= pt_d;
      term_q      <= term_d;
      pass_q      <= pass_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/polynomial_bisection_root_core.sv -----
// ----------------------------------------------------------------------------
// polynomial_bisection_root_core
// Bisection root finder for a polynomial of degree up to five in Q16.16.
//
//   channel  direction  handshake                    payload
//   cfg      in         cfg_we_i                     cfg_idx_i, cfg_data_i
//   in       in         in_valid_i / in_ready_o      lower_bound_i, upper_bound_i
//   out      out        out_valid_o / out_ready_i    root_o, converged_o
//
// One request at a time. Each polynomial evaluation steps through terms 0 to d
// on the single shared multiplier (d = effective degree), a pass evaluates the
// low bound, high bound and midpoint, and a request runs up to MAX_ITER passes.
// Reset clears the controller and loads register reset values.
// A new request is taken while a result waits at the output register; a
// finished search holds in its last state until the output register frees.
// ----------------------------------------------------------------------------
module polynomial_bisection_root_core import pbr_pkg::*; #(
  parameter int unsigned MAX_DEGREE = DEF_MAX_DEGREE,
  parameter int unsigned MAX_ITER   = DEF_MAX_ITER,
  parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DATA_W-1:0] lower_bound_i,
  input  logic signed [DATA_W-1:0] upper_bound_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] root_o,
  output logic                     converged_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  pbr_ctrl #(
    .MAX_ITER (MAX_ITER)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and registers
  pbr_datapath #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .lower_bound_i (lower_bound_i),
    .upper_bound_i (upper_bound_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .root_o        (root_o),
    .converged_o   (converged_o)
  );

endmodule

// ----- rtl/pbr_checker.sv -----
// ----------------------------------------------------------------------------
// pbr_checker
// Port-level assertions for the bisection root core, bound to the top level.
// ----------------------------------------------------------------------------
`include "polynomial_bisection_root_core_defines.svh"

module pbr_checker import pbr_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DATA_W-1:0] root_o,
  input logic                     converged_o
);

  // a failed search always reports a zero root
  `PBR_ASSERT_IMP(a_noconv_zero, out_valid_o && !converged_o, root_o == '0)

  // one request in flight: ready drops right after an accept
  `PBR_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // a result only appears at the end of a search
  `PBR_ASSERT_IMP(a_result_after_busy, $rose(out_valid_o), $past(!in_ready_o))

  // stalled result holds
  `PBR_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(root_o) && $stable(converged_o))

endmodule

bind polynomial_bisection_root_core pbr_checker u_pbr_checker (.*);

// ----- tb/polynomial_bisection_root_core_test.sv -----
// ----------------------------------------------------------------------------
// polynomial_bisection_root_core_test
// Self-checking bench for the bisection root core. A local fixed-point model
// predicts root and converged for every request; results are checked in
// order. Directed requests cover reset values, extreme bounds, saturation,
// degree clamping and the iteration limit; random phases then load
// polynomials built from integer roots or noise and send ordered, reversed or equal bounds
// under bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module polynomial_bisection_root_core_test;
  import pbr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DEGREE = DEF_MAX_DEGREE;
  localparam int unsigned MAX_ITER   = DEF_MAX_ITER;
  localparam int unsigned FRAC_BITS  = DEF_FRAC_BITS;
  localparam int unsigned NUM_COEF   = MAX_DEGREE + 1;

  localparam int CLK_HALF       = 5;
  localparam int CYCLE_LIMIT    = 10_000_000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int RANDOM_ITEMS   = 750;
  localparam int PASS_BUDGET    = 40;
  localparam int PICK_TRIES     = 24;
  localparam int BOUND_SPAN     = 6 << 16;
  localparam int REPORT_LIMIT   = 200;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_BASE = '0;

  typedef logic signed [DATA_W-1:0] fix_t;

  typedef struct packed {
    fix_t root;
    logic converged;
  } root_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_LONG
  } stall_mode_e;

  localparam fix_t FIX_ONE  = fix_t'(1 << FRAC_BITS);
  localparam fix_t FIX_HALF = fix_t'(1 << (FRAC_BITS - 1));
  localparam fix_t FIX_MAX  = 32'sh7FFF_FFFF;
  localparam fix_t FIX_MIN  = 32'sh8000_0000;
  localparam fix_t FIX_JUNK = 32'sh5A5A_A5A5;
  localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
  localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  fix_t                 lower_bound;
  fix_t                 upper_bound;
  logic                 out_valid;
  logic                 out_ready;
  fix_t                 root;
  logic                 converged;

  // mirror of the register file
  fix_t             coef_mirror [NUM_COEF];
  logic [DEG_W-1:0] degree_mirror;
  logic [TOL_W-1:0] tol_mirror;
  fix_t             coef_stage  [NUM_COEF];

  root_result_t expected_roots [$];
  root_result_t oldest_root;
  int           error_count = 0;
  int           cycle_count = 0;
  stall_mode_e  stall_mode;
  int           stall_span;
  int           stall_step = 0;

  polynomial_bisection_root_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .lower_bound_i (lower_bound),
    .upper_bound_i (upper_bound),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .root_o        (root),
    .converged_o   (converged)
  );

  always #CLK_HALF clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // fixed-point model
  // ---------------------------------------------------------------------------
  function automatic fix_t clip32(logic signed [63:0] v);
    if (v > WIDE_MAX) return FIX_MAX;
    if (v < WIDE_MIN) return FIX_MIN;
    return fix_t'(v[DATA_W-1:0]);
  endfunction

  // exact product, floor shift, saturate
  function automatic fix_t fx_product(fix_t a, fix_t b);
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    wa = a;
    wb = b;
    return clip32((wa * wb) >>> FRAC_BITS);
  endfunction

  // power-form evaluation with saturating accumulate
  function automatic fix_t poly_value(fix_t x);
    fix_t               acc;
    fix_t               pow_x;
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    int unsigned        top;
    acc   = '0;
    pow_x = FIX_ONE;
    top   = degree_mirror;
    if (top > MAX_DEGREE) top = MAX_DEGREE;
    for (int i = 0; i <= top; i++) begin
      wa    = acc;
      wb    = fx_product(pow_x, coef_mirror[i]);
      acc   = clip32(wa + wb);
      pow_x = fx_product(pow_x, x);
    end
    return acc;
  endfunction

  // magnitude at full width, so the most negative value never passes
  function automatic bit within_tol(fix_t v);
    logic signed [63:0] mag;
    logic signed [63:0] limit;
    mag   = v;
    limit = {33'b0, tol_mirror};
    if (mag < 0) mag = -mag;
    return mag < limit;
  endfunction

  // Bisection search. Returns 0 when pass_cap runs out before the search
  // settles; the full iteration limit always settles.
  function automatic bit search_root(input fix_t lo_in, input fix_t hi_in,
                                     input int pass_cap, output root_result_t res);
    fix_t               lo;
    fix_t               hi;
    fix_t               mid;
    fix_t               vl;
    fix_t               vr;
    fix_t               vm;
    logic signed [63:0] wlo;
    logic signed [63:0] whi;
    logic signed [63:0] wmid;
    lo            = lo_in;
    hi            = hi_in;
    res.root      = '0;
    res.converged = 1'b0;
    for (int pass = 0; pass < MAX_ITER; pass++) begin
      if (pass >= pass_cap) return 1'b0;
      vl = poly_value(lo);
      if (within_tol(vl)) begin
        res.root      = lo;
        res.converged = 1'b1;
        return 1'b1;
      end
      vr = poly_value(hi);
      if (within_tol(vr)) begin
        res.root      = hi;
        res.converged = 1'b1;
        return 1'b1;
      end
      wlo  = lo;
      whi  = hi;
      wmid = (wlo + whi) >>> 1;
      mid  = fix_t'(wmid[DATA_W-1:0]);
      vm   = poly_value(mid);
      if ((vm < 0 && vr > 0) || (vm > 0 && vr < 0)) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    if (idx < NUM_COEF) begin
      coef_mirror[idx] = fix_t'(data);
    end else if (idx == REG_DEGREE) begin
      degree_mirror = data[DEG_W-1:0];
    end else begin
      tol_mirror = data[TOL_W-1:0];
    end
  endtask

  // write every register from coef_stage and the given words
  task automatic load_config(input logic [DATA_W-1:0] deg_word,
                             input logic [DATA_W-1:0] tol_word);
    for (int i = 0; i < NUM_COEF; i++) begin
      write_reg(REG_COEF_BASE + CFG_IDX_W'(i), coef_stage[i]);
    end
    write_reg(REG_DEGREE, deg_word);
    write_reg(REG_TOL, tol_word);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // present one request and hold it until accepted
  task automatic send_bounds(input fix_t lo, input fix_t hi);
    root_result_t res;
    void'(search_root(lo, hi, MAX_ITER, res));
    @(negedge clk);
    lower_bound = lo;
    upper_bound = hi;
    in_valid    = 1'b1;
    expected_roots.push_back(res);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drop_request();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain_results();
    drop_request();
    while (expected_roots.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_roots.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: unexpected result root=%h converged=%b", $time, root, converged);
      end else begin
        oldest_root = expected_roots.pop_front();
        if (root !== oldest_root.root) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: root expected %h actual %h", $time, oldest_root.root, root);
        end
        if (converged !== oldest_root.converged) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: converged expected %b actual %b", $time,
                     oldest_root.converged, converged);
        end
      end
    end
  end

  // output stall pattern, mode redrawn after each random span
  initial begin
    out_ready = 1'b0;
    forever begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_span = $urandom_range(64, 512);
      repeat (stall_span) begin
        @(negedge clk);
        stall_step++;
        case (stall_mode)
          STALL_NONE:     out_ready = 1'b1;
          STALL_RANDOM:   out_ready = $urandom_range(0, 1);
          STALL_PERIODIC: out_ready = (stall_step % 7) < 3;
          default:        out_ready = (stall_step % 40) >= 30;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // reset leaves p = 0 and tolerance 1, so the left bound is taken
  task automatic test_reset_values();
    send_bounds(FIX_MIN, FIX_MAX);
    send_bounds(FIX_MAX, FIX_MIN);
    drain_results();
  endtask

  // p(x) = x - 1.5: bracketing, reversed, right-bound hit, equal bounds
  task automatic test_linear_root();
    coef_stage = '{-(FIX_ONE + FIX_HALF), FIX_ONE, FIX_JUNK, FIX_JUNK, FIX_JUNK, FIX_JUNK};
    load_config(32'd1, 32'h0000_0100);
    send_bounds(32'sd0, 4 * FIX_ONE);
    send_bounds(4 * FIX_ONE, 32'sd0);
    send_bounds(32'sd0, FIX_ONE + FIX_HALF);
    send_bounds(FIX_ONE + FIX_HALF, FIX_ONE + FIX_HALF);
    send_bounds(-2 * FIX_ONE, 5 * FIX_ONE);
    drain_results();
  endtask

  // p(x) = x^5 - 1, degree codes above five act as five
  task automatic test_degree_clamp();
    coef_stage = '{-FIX_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, FIX_ONE};
    load_config(32'd7, 32'h0000_1000);
    send_bounds(32'sd0, 2 * FIX_ONE);
    send_bounds(-FIX_ONE, FIX_ONE + FIX_HALF);
    drain_results();
    load_config(32'hFFFF_FFF6, 32'h0000_1000);
    send_bounds(FIX_HALF, 3 * FIX_ONE);
    drain_results();
    load_config(32'd5, 32'h0000_1000);
    send_bounds(FIX_HALF, 3 * FIX_ONE);
    drain_results();
  endtask

  // products and sums hitting both saturation rails at extreme bounds
  task automatic test_saturation();
    coef_stage = '{FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX};
    load_config(32'd5, 32'd16);
    send_bounds(FIX_MIN, FIX_MAX);
    send_bounds(FIX_MAX, FIX_MIN);
    drain_results();
    coef_stage = '{FIX_MIN, FIX_MAX, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN};
    load_config(32'd1, 32'h7FFF_FFFF);
    send_bounds(FIX_MAX, 32'sd0);
    send_bounds(FIX_MIN, FIX_MAX);
    drain_results();
  endtask

  // constant polynomial: immediate hit, then the iteration limit
  task automatic test_degree_zero();
    coef_stage = '{32'sh0000_0010, FIX_MAX, FIX_MIN, FIX_JUNK, FIX_MAX, FIX_MIN};
    load_config(32'd0, 32'h0000_0100);
    send_bounds(32'sh1234_5678, -32'sd5);
    drain_results();
    coef_stage[0] = FIX_ONE;
    load_config(32'd0, 32'h0000_0100);
    send_bounds(-FIX_ONE, FIX_ONE);
    drain_results();
  endtask

  // tolerance bit 31 is dropped, leaving zero: nothing is ever accepted
  task automatic test_zero_tolerance();
    coef_stage = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
    load_config(32'd0, 32'h8000_0000);
    send_bounds(FIX_ONE, 2 * FIX_ONE);
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // random phases
  // ---------------------------------------------------------------------------
  function automatic fix_t near_value();
    return fix_t'($urandom_range(0, 2 * BOUND_SPAN)) - fix_t'(BOUND_SPAN);
  endfunction

  // Load a polynomial: either integer roots times a small lead, or noise
  // coefficients with |c0| below tolerance. anchor is a point that is
  // always accepted.
  task automatic program_random_polynomial(output fix_t anchor);
    int               cint [NUM_COEF];
    int               nxt  [NUM_COEF];
    int               r;
    int               lead;
    int               amp;
    int unsigned      deg_code;
    int unsigned      eff;
    bit               noise;
    logic [TOL_W-1:0] tol_v;
    logic [DATA_W-1:0] deg_word;
    logic [DATA_W-1:0] tol_word;
    fix_t             c0;
    deg_code = $urandom_range(0, 7);
    eff      = (deg_code > MAX_DEGREE) ? MAX_DEGREE : deg_code;
    noise    = (eff == 0) || ($urandom_range(0, 3) == 0);
    anchor   = '0;
    // coefficients above the degree get junk
    for (int i = 0; i < NUM_COEF; i++) coef_stage[i] = fix_t'($urandom);
    if (noise) begin
      case ($urandom_range(0, 2))
        0:       amp = 18;
        1:       amp = 21;
        default: amp = 31;
      endcase
      if (amp == 31) tol_v = $urandom_range(1 << 16, 32'h7FFF_FFFF);
      else           tol_v = $urandom_range(1 << 6, 1 << 18);
      for (int i = 1; i <= eff; i++) begin
        coef_stage[i] = fix_t'($urandom) >>> (31 - amp);
      end
      c0 = fix_t'($urandom_range(0, tol_v - 1));
      if ($urandom_range(0, 1)) c0 = -c0;
      coef_stage[0] = c0;
    end else begin
      lead = $urandom_range(1, 2);
      if ($urandom_range(0, 1)) lead = -lead;
      cint    = '{default: 0};
      cint[0] = lead;
      // multiply in (x - r) for each root
      for (int k = 0; k < eff; k++) begin
        r = $urandom_range(0, 6) - 3;
        if (k == 0) anchor = fix_t'(r * (1 << FRAC_BITS));
        nxt[0] = -r * cint[0];
        for (int i = 1; i < NUM_COEF; i++) nxt[i] = cint[i-1] - r * cint[i];
        cint = nxt;
      end
      for (int i = 0; i <= eff; i++) coef_stage[i] = fix_t'(cint[i] * (1 << FRAC_BITS));
      if ($urandom_range(0, 3) == 0) tol_v = $urandom_range(1, 1 << 8);
      else                           tol_v = $urandom_range(1 << 8, 1 << 17);
    end
    // upper bits of the narrow registers carry noise
    deg_word = $urandom;
    deg_word[DEG_W-1:0] = DEG_W'(deg_code);
    tol_word = $urandom;
    tol_word[TOL_W-1:0] = tol_v;
    load_config(deg_word, tol_word);
  endtask

  // draw bounds whose search settles within the pass budget
  task automatic pick_bounds(input fix_t anchor, output fix_t lo, output fix_t hi);
    root_result_t res;
    fix_t         swap;
    int           kind;
    for (int attempt = 0; attempt < PICK_TRIES; attempt++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          lo = fix_t'($urandom);
          hi = fix_t'($urandom);
        end
        1: begin
          lo = $urandom_range(0, 1) ? anchor : near_value();
          hi = lo;
        end
        default: begin
          lo = near_value();
          hi = near_value();
          // mostly ordered, sometimes reversed
          if ((kind == 2) == (lo < hi)) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
          end
        end
      endcase
      if (search_root(lo, hi, PASS_BUDGET, res)) return;
    end
    lo = anchor;
    hi = near_value();
  endtask

  task automatic test_random_phases();
    int   sent;
    int   phase_len;
    int   burst;
    int   gap;
    fix_t anchor;
    fix_t lo;
    fix_t hi;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      program_random_polynomial(anchor);
      phase_len = $urandom_range(40, 110);
      burst     = $urandom_range(1, 12);
      for (int k = 0; k < phase_len; k++) begin
        pick_bounds(anchor, lo, hi);
        // sender gap between bursts, sometimes none
        if (burst == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          if (gap != 0) begin
            drop_request();
            repeat (gap - 1) @(negedge clk);
          end
          burst = $urandom_range(1, 12);
        end
        send_bounds(lo, hi);
        burst--;
        sent++;
      end
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    lower_bound = '0;
    upper_bound = '0;
    for (int i = 0; i < NUM_COEF; i++) coef_mirror[i] = '0;
    degree_mirror = DEGREE_RST;
    tol_mirror    = TOL_RST;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_linear_root();
    test_degree_clamp();
    test_saturation();
    test_degree_zero();
    test_zero_tolerance();
    test_random_phases();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pbr_pkg.sv
rtl/pbr_datapath.sv
rtl/pbr_ctrl.sv
rtl/polynomial_bisection_root_core.sv
rtl/pbr_checker.sv
tb/polynomial_bisection_root_core_test.sv
